[sv/gda_pkg.sv]
// Shared types, constants and month table for the Gregorian date adder.
// No dependencies; imported by gda_ctrl, gda_dp and gregorian_date_add_days_core.
`default_nettype none

package gda_pkg;

    localparam int unsigned ADD_BITS_DEF    = 16;
    localparam int unsigned MONTH_W         = 4;
    localparam int unsigned DAY_W           = 5;
    localparam int unsigned YEAR_W          = 14;
    localparam int unsigned DAYS_W          = 16;
    localparam int unsigned ERR_W           = 2;
    localparam int unsigned KW              = 4;

    localparam logic [YEAR_W-1:0]  YEAR_MAX       = 14'd16383;
    localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST      = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_DEC_LAST   = 5'd31;
    // year mod 25 with year mod 4 and mod 16 gives the century rules
    localparam logic [YEAR_W-1:0]  YEAR_DIV       = 14'd25;
    localparam logic [YEAR_W-1:0]  YEAR_DIV_LAST  = 14'd24;
    localparam logic [KW-1:0]      REDUCE_TOP     = 4'd9;

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INVALID  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_WALK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic reduce;
        logic check;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic reduce_last;
        logic left_zero;
        logic err_set;
    } t_status;

    function automatic logic [DAY_W-1:0] month_day_count(input logic [MONTH_W-1:0] m,
                                                         input logic leap);
        logic [DAY_W-1:0] n;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
                4'd2:                                        n = leap ? 5'd29 : 5'd28;
                default:                                     n = 5'd0;
            endcase
            return n;
        end
    endfunction

endpackage

`default_nettype wire

[sv/gda_ctrl.sv]
// Controller state machine for the date adder: sequences load, year reduction,
// check, month walk and the result handshake. Depends on gda_pkg.
`default_nettype none

module gda_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    output gda_pkg::t_cmd     o_cmd,
    input  gda_pkg::t_status  i_status
);
    import gda_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_status.reduce_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                if (i_status.err_set || i_status.left_zero) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.reduce, o_cmd.check, o_cmd.step}))
        else $error("more than one datapath command");
    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && i_status.err_set) |=> (r_state == ST_OUT))
        else $error("walk did not stop on error");
    a_check_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |=> (r_state == ST_WALK))
        else $error("check not followed by walk");

endmodule

`default_nettype wire

[sv/gda_dp.sv]
// Datapath for the date adder: date registers, remaining-day counter, year mod 25
// reduction and the one-month step. Depends on gda_pkg.
`default_nettype none

module gda_dp #(
    parameter int unsigned ADD_BITS = gda_pkg::ADD_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  gda_pkg::t_cmd                 i_cmd,
    output gda_pkg::t_status              o_status,
    input  wire [gda_pkg::MONTH_W-1:0]    i_month,
    input  wire [gda_pkg::DAY_W-1:0]      i_day,
    input  wire [gda_pkg::YEAR_W-1:0]     i_year,
    input  wire [gda_pkg::DAYS_W-1:0]     i_days,
    output logic [gda_pkg::MONTH_W-1:0]   o_month,
    output logic [gda_pkg::DAY_W-1:0]     o_day,
    output logic [gda_pkg::YEAR_W-1:0]    o_year,
    output logic [gda_pkg::ERR_W-1:0]     o_err
);
    import gda_pkg::*;

    logic [MONTH_W-1:0]  r_m;
    logic [DAY_W-1:0]    r_d;
    logic [YEAR_W-1:0]   r_y;
    logic [YEAR_W-1:0]   r_ymod;
    logic [KW-1:0]       r_k;
    logic [ADD_BITS-1:0] r_left;
    logic [ERR_W-1:0]    r_err;

    logic [ADD_BITS+DAYS_W-1:0] w_days_ext;
    logic [YEAR_W-1:0]          w_sub;
    logic                       w_leap;
    logic [DAY_W-1:0]           w_dim;
    logic [DAY_W:0]             w_to_next;
    logic                       w_cross;

    assign w_days_ext = {{ADD_BITS{1'b0}}, i_days};
    assign w_sub      = YEAR_DIV << r_k;
    assign w_leap     = (r_y[1:0] == 2'b00) &&
                        ((r_ymod != '0) || (r_y[3:0] == 4'b0000));
    assign w_dim      = month_day_count(r_m, w_leap);
    assign w_to_next  = {1'b0, w_dim} - {1'b0, r_d} + 6'd1;
    assign w_cross    = r_left >= ADD_BITS'(w_to_next);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m    <= i_month;
            r_d    <= i_day;
            r_y    <= i_year;
            r_ymod <= i_year;
            r_k    <= REDUCE_TOP;
            r_left <= w_days_ext[ADD_BITS-1:0];
            r_err  <= ERR_OK;
        end else if (i_cmd.reduce) begin
            if (r_ymod >= w_sub) begin
                r_ymod <= r_ymod - w_sub;
            end
            r_k <= r_k - 1'b1;
        end else if (i_cmd.check) begin
            if (r_y == '0 || r_d == '0 || r_d > w_dim) begin
                r_err <= ERR_INVALID;
            end
        end else if (i_cmd.step) begin
            if (w_cross) begin
                r_left <= r_left - ADD_BITS'(w_to_next);
                r_d    <= DAY_FIRST;
                if (r_m == MONTH_DEC) begin
                    if (r_y == YEAR_MAX) begin
                        r_d   <= DAY_DEC_LAST;
                        r_err <= ERR_OVERFLOW;
                    end else begin
                        r_m    <= MONTH_JAN;
                        r_y    <= r_y + 1'b1;
                        r_ymod <= (r_ymod == YEAR_DIV_LAST) ? '0 : r_ymod + 1'b1;
                    end
                end else begin
                    r_m <= r_m + 1'b1;
                end
            end else begin
                r_d    <= r_d + r_left[DAY_W-1:0];
                r_left <= '0;
            end
        end
    end

    assign o_status.reduce_last = (r_k == '0);
    assign o_status.left_zero   = (r_left == '0);
    assign o_status.err_set     = (r_err != ERR_OK);

    assign o_month = r_m;
    assign o_day   = r_d;
    assign o_year  = r_y;
    assign o_err   = r_err;

    a_step_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_err == ERR_OK && r_left != '0))
        else $error("step issued with nothing to do");
    a_ymod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_ymod < YEAR_DIV))
        else $error("year residue out of range");
    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_d != '0 && r_d <= w_dim))
        else $error("day outside month during walk");

endmodule

`default_nettype wire

[sv/gregorian_date_add_days_core.sv]
// Top level of the Gregorian date adder: stream ports, controller and datapath.
// Depends on gda_pkg, gda_ctrl and gda_dp.
//
//  channel  dir  tdata (low bit up)                        tuser
//  s        in   start_month, start_day, start_year,       -
//                days_to_add, pad
//  m        out  end_month, end_day, end_year, pad          error
//
// One item at a time: accept, year mod 25 reduction by shifted subtraction,
// a validity check, one step per month crossed, a step for any days left in the
// last month, a test that the count reached zero, then the output.
// For a large day count the month walk takes most of the time.
// i_rst_n is synchronous, active low, and clears the controller only.
// A result holds on the m side until taken; no new item is taken meanwhile.
`default_nettype none

module gregorian_date_add_days_core #(
    parameter int unsigned ADD_BITS = gda_pkg::ADD_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [39:0] i_s_tdata,   // start_month, start_day, start_year, days_to_add, pad
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // end_month, end_day, end_year, pad
    output logic [1:0]  o_m_tuser    // error
);
    import gda_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    logic [MONTH_W-1:0] w_month;
    logic [DAY_W-1:0]   w_day;
    logic [YEAR_W-1:0]  w_year;
    logic [ERR_W-1:0]   w_err;

    gda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    gda_dp #(
        .ADD_BITS (ADD_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_month  (i_s_tdata[3:0]),
        .i_day    (i_s_tdata[8:4]),
        .i_year   (i_s_tdata[22:9]),
        .i_days   (i_s_tdata[38:23]),
        .o_month  (w_month),
        .o_day    (w_day),
        .o_year   (w_year),
        .o_err    (w_err)
    );

    assign o_m_tdata = {1'b0, w_year, w_day, w_month};
    assign o_m_tuser = w_err;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while result pending");
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ERR_OK || o_m_tuser == ERR_INVALID ||
                        o_m_tuser == ERR_OVERFLOW))
        else $error("bad error code");
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ERR_OK) |->
            (w_month >= MONTH_JAN && w_month <= MONTH_DEC && w_day != '0 && w_year != '0))
        else $error("result date malformed");

endmodule

`default_nettype wire
